/* sv/vpd_pkg.sv */
`timescale 1ns / 1ps

package vpd_pkg;

    // Palette geometry.
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int COMP_W              = 6;
    localparam int ENTRY_W             = 3 * COMP_W;

    // Field types of the request and response channels.
    typedef logic [1:0]        t_action;
    typedef logic [1:0]        t_port;
    typedef logic [7:0]        t_byte;
    typedef logic [COMP_W-1:0] t_comp;
    typedef logic [1:0]        t_phase;

    // Action codes.
    localparam t_action ACT_READ   = 2'd0;
    localparam t_action ACT_WRITE  = 2'd1;
    localparam t_action ACT_LOOKUP = 2'd2;

    // Port codes.
    localparam t_port PORT_MASK  = 2'd0;
    localparam t_port PORT_RADDR = 2'd1;
    localparam t_port PORT_WADDR = 2'd2;
    localparam t_port PORT_DATA  = 2'd3;

    // Component phase codes; the last one is never reached by stepping.
    localparam t_phase PH_RED   = 2'd0;
    localparam t_phase PH_GREEN = 2'd1;
    localparam t_phase PH_BLUE  = 2'd2;
    localparam t_phase PH_STUCK = 2'd3;

    // Byte constants.
    localparam t_byte MASK_RESET      = 8'hff;
    localparam t_byte STATE_READ_MODE = 8'h03;
    localparam t_byte STATE_WRITE_MODE = 8'h00;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic captured;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/vpd_req_if.sv */
`timescale 1ns / 1ps

interface vpd_req_if import vpd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_action action;
    t_port   port;
    t_byte   write_data;
    t_byte   pixel_index;

    modport source (output valid, output action, output port, output write_data,
                    output pixel_index, input ready);
    modport sink (input valid, input action, input port, input write_data,
                  input pixel_index, output ready);
endinterface

/* sv/vpd_rsp_if.sv */
`timescale 1ns / 1ps

interface vpd_rsp_if import vpd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte read_data;
    t_comp pixel_red;
    t_comp pixel_green;
    t_comp pixel_blue;

    modport source (output valid, output read_data, output pixel_red,
                    output pixel_green, output pixel_blue, input ready);
    modport sink (input valid, input read_data, input pixel_red,
                  input pixel_green, input pixel_blue, output ready);
endinterface

/* sv/vga_palette_dac_registers.sv */
`timescale 1ns / 1ps

// VGA palette DAC register block.
// The request channel i_req carries one bus read, bus write or pixel lookup
// per transfer; the response channel o_rsp returns exactly one result per
// request, in order: the read byte for a bus read, the 6-bit red, green and
// blue of the entry for a lookup, and all zeros otherwise.
// Each request goes through capture, a registered palette read, and
// an execute cycle that updates the address registers, writes the palette
// and loads the output register. A new request is taken only after the
// previous one has executed. A response is valid from the output register
// once the execute cycle of its request has loaded it.
// When the receiver holds ready low, the result waits in the output
// register and the next request is captured and read, then waits before
// its execute cycle until the output register is free.
// Reset clears the pixel mask to all ones, both addresses and the phase to
// zero, selects read mode and marks every palette entry as zero at once.
module vga_palette_dac_registers import vpd_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vpd_req_if.sink   i_req,
    vpd_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    vpd_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    vpd_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

/* sv/vpd_datapath.sv */
`timescale 1ns / 1ps

module vpd_datapath import vpd_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    vpd_req_if.sink          i_req,
    vpd_rsp_if.source        o_rsp
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Reduces an 8-bit address modulo the palette size by restoring
    // subtraction; the result is correct only while the quotient is below 16,
    // that is, for a palette of at least 16 entries.
    function automatic logic [IDX_W-1:0] entry_of(input t_byte a);
        logic [11:0] v;
        v = {4'b0000, a};
        for (int k = 3; k >= 0; k--) begin
            if (v >= 12'(PALETTE_ENTRIES << k)) begin
                v = v - 12'(PALETTE_ENTRIES << k);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    // Captured request.
    t_action r_action;
    t_port   r_port;
    t_byte   r_wdata;
    t_byte   r_pidx;

    // Architectural registers.
    t_byte  r_mask, n_mask;
    t_byte  r_rd_addr, n_rd_addr;
    t_byte  r_wr_addr, n_wr_addr;
    t_phase r_phase, n_phase;
    logic   r_rd_mode, n_rd_mode;

    // Palette memory with a valid bit per entry; invalid entries read as zero.
    logic [ENTRY_W-1:0]         r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [ENTRY_W-1:0]         r_mem_q;
    logic                       r_valid_q;

    // Response register.
    logic  r_out_valid;
    t_byte r_read_data, n_read_data;
    t_comp r_red, n_red;
    t_comp r_green, n_green;
    t_comp r_blue, n_blue;

    t_byte              sel_addr;
    logic [IDX_W-1:0]   fetch_idx;
    logic [ENTRY_W-1:0] old_entry;
    logic [ENTRY_W-1:0] merged;
    t_comp              cur_comp;
    logic               mem_we;
    logic               capture;

    assign i_req.ready = i_cmd.ready;
    assign capture     = i_req.valid & i_cmd.ready;

    assign o_sts.captured = capture;
    assign o_sts.out_free = ~r_out_valid | o_rsp.ready;

    // Capture an item on an input transfer.
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_action <= i_req.action;
            r_port   <= i_req.port;
            r_wdata  <= i_req.write_data;
            r_pidx   <= i_req.pixel_index;
        end
    end

    // Palette address for the captured item.
    always_comb begin
        case (r_action)
            ACT_LOOKUP: sel_addr = r_pidx & r_mask;
            ACT_WRITE:  sel_addr = r_wr_addr;
            default:    sel_addr = r_rd_addr;
        endcase
        fetch_idx = entry_of(sel_addr);
    end

    // Registered palette read.
    always_ff @(posedge i_clk) begin
        r_mem_q   <= r_mem[fetch_idx];
        r_valid_q <= r_valid[fetch_idx];
    end

    // Palette write.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[fetch_idx] <= merged;
        end
    end

    assign old_entry = r_valid_q ? r_mem_q : '0;

    // Current component and the entry with one component replaced.
    always_comb begin
        case (r_phase)
            PH_RED: begin
                cur_comp = old_entry[3*COMP_W-1:2*COMP_W];
                merged   = {r_wdata[COMP_W-1:0], old_entry[2*COMP_W-1:0]};
            end
            PH_GREEN: begin
                cur_comp = old_entry[2*COMP_W-1:COMP_W];
                merged   = {old_entry[3*COMP_W-1:2*COMP_W], r_wdata[COMP_W-1:0],
                            old_entry[COMP_W-1:0]};
            end
            PH_BLUE: begin
                cur_comp = old_entry[COMP_W-1:0];
                merged   = {old_entry[3*COMP_W-1:COMP_W], r_wdata[COMP_W-1:0]};
            end
            default: begin
                cur_comp = '0;
                merged   = old_entry;
            end
        endcase
    end

    // Execute the captured item when the controller commits it.
    always_comb begin
        n_mask      = r_mask;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_phase     = r_phase;
        n_rd_mode   = r_rd_mode;
        n_read_data = '0;
        n_red       = '0;
        n_green     = '0;
        n_blue      = '0;
        mem_we      = 1'b0;
        if (i_cmd.commit) begin
            case (r_action)
                ACT_READ: begin
                    case (r_port)
                        PORT_MASK:  n_read_data = r_mask;
                        PORT_RADDR: n_read_data = r_rd_mode ? STATE_READ_MODE
                                                            : STATE_WRITE_MODE;
                        PORT_WADDR: n_read_data = r_wr_addr;
                        default: begin
                            if (r_phase != PH_STUCK) begin
                                n_read_data = {2'b00, cur_comp};
                                if (r_phase == PH_BLUE) begin
                                    n_phase   = PH_RED;
                                    n_rd_addr = r_rd_addr + 8'd1;
                                end else begin
                                    n_phase = r_phase + 2'd1;
                                end
                            end
                        end
                    endcase
                end
                ACT_WRITE: begin
                    case (r_port)
                        PORT_MASK: n_mask = r_wdata;
                        PORT_RADDR: begin
                            n_rd_addr = r_wdata;
                            n_wr_addr = r_wdata + 8'd1;
                            n_phase   = PH_RED;
                            n_rd_mode = 1'b1;
                        end
                        PORT_WADDR: begin
                            n_wr_addr = r_wdata;
                            n_rd_addr = r_wdata - 8'd1;
                            n_phase   = PH_RED;
                            n_rd_mode = 1'b0;
                        end
                        default: begin
                            if (r_phase != PH_STUCK) begin
                                mem_we = 1'b1;
                                if (r_phase == PH_BLUE) begin
                                    n_phase   = PH_RED;
                                    n_wr_addr = r_wr_addr + 8'd1;
                                end else begin
                                    n_phase = r_phase + 2'd1;
                                end
                            end
                        end
                    endcase
                end
                ACT_LOOKUP: begin
                    n_red   = old_entry[3*COMP_W-1:2*COMP_W];
                    n_green = old_entry[2*COMP_W-1:COMP_W];
                    n_blue  = old_entry[COMP_W-1:0];
                end
                default: begin
                    n_read_data = '0;
                end
            endcase
        end
    end

    // Control and address registers, with the valid bits of the palette.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= MASK_RESET;
            r_rd_addr <= '0;
            r_wr_addr <= '0;
            r_phase   <= PH_RED;
            r_rd_mode <= 1'b1;
            r_valid   <= '0;
        end else begin
            r_mask    <= n_mask;
            r_rd_addr <= n_rd_addr;
            r_wr_addr <= n_wr_addr;
            r_phase   <= n_phase;
            r_rd_mode <= n_rd_mode;
            if (mem_we) begin
                r_valid[fetch_idx] <= 1'b1;
            end
        end
    end

    // Output register: loaded on commit, emptied on an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_read_data <= n_read_data;
            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_read_data;
    assign o_rsp.pixel_red   = r_red;
    assign o_rsp.pixel_green = r_green;
    assign o_rsp.pixel_blue  = r_blue;

endmodule

/* sv/vpd_controller.sv */
`timescale 1ns / 1ps

module vpd_controller import vpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands. The fetch state holds the palette read until
    // the output register can take the result.
    always_comb begin
        n_state      = r_state;
        o_cmd.ready  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.captured) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (i_sts.out_free) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
